// File: hw/rtl/cbf_pkg.sv
// shared constants for the cubic bezier curve flattener
package cbf_pkg;

  localparam int MAX_POINTS_DEF = 64;  // default cap on points per curve
  localparam int MIN_POINTS     = 4;   // smaller counts are raised to this
  localparam int COORD_W        = 16;  // q2.14 coordinate width
  localparam int CNT_W          = 7;   // point_count field width
  localparam int NUM_COORDS     = 8;   // p0.x p0.y p1.x p1.y p2.x p2.y p3.x p3.y

endpackage

// File: hw/rtl/cbf_div.sv
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
module cbf_div import cbf_pkg::*; #(
  parameter int DEN_W = 18,
  parameter int NUM_W = DEN_W + 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  logic [NUM_W-1:0]     in_num_x,
  input  logic [NUM_W-1:0]     in_num_y,
  input  logic [DEN_W-1:0]     in_den,
  output logic                 out_valid,
  output logic                 out_last,
  output logic [COORD_W-1:0]   out_q_x,
  output logic [COORD_W-1:0]   out_q_y
);

  localparam int NS = COORD_W;

  logic               v_r    [NS];
  logic               last_r [NS];
  logic [NUM_W-1:0]   rx_r   [NS];
  logic [NUM_W-1:0]   ry_r   [NS];
  logic [DEN_W-1:0]   den_r  [NS];
  logic [COORD_W-1:0] qx_r   [NS];
  logic [COORD_W-1:0] qy_r   [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      localparam int BIT = NS - 1 - k;
      logic [NUM_W-1:0]   rx_in, ry_in, sub;
      logic [DEN_W-1:0]   den_in;
      logic [COORD_W-1:0] qx_in, qy_in;
      logic               v_in, last_in;
      logic               gx, gy;

      if (k == 0) begin : g_first
        assign rx_in   = in_num_x;
        assign ry_in   = in_num_y;
        assign den_in  = in_den;
        assign qx_in   = '0;
        assign qy_in   = '0;
        assign v_in    = in_valid;
        assign last_in = in_last;
      end else begin : g_next
        assign rx_in   = rx_r[k-1];
        assign ry_in   = ry_r[k-1];
        assign den_in  = den_r[k-1];
        assign qx_in   = qx_r[k-1];
        assign qy_in   = qy_r[k-1];
        assign v_in    = v_r[k-1];
        assign last_in = last_r[k-1];
      end

      assign sub = NUM_W'(den_in) << BIT;
      assign gx  = (rx_in >= sub);
      assign gy  = (ry_in >= sub);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          last_r[k] <= last_in;
          den_r[k]  <= den_in;
          rx_r[k]   <= gx ? (rx_in - sub) : rx_in;
          ry_r[k]   <= gy ? (ry_in - sub) : ry_in;
          qx_r[k]   <= qx_in | (COORD_W'(gx) << BIT);
          qy_r[k]   <= qy_in | (COORD_W'(gy) << BIT);
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NS-1];
  assign out_last  = last_r[NS-1];
  assign out_q_x   = qx_r[NS-1];
  assign out_q_y   = qy_r[NS-1];

endmodule

// File: hw/rtl/cubic_bezier_curve_flattener_top.sv
// cubic bezier curve flattener: point sequencer, weight and product pipeline, divider
// throughput: one point per cycle unless the output stalls; a new curve is not taken until the
//   sequencer has issued the last step of the current one, one parameter step per cycle when not stalled
// output stalls freeze the whole pipeline, nothing is dropped or repeated
// reset (rst_n low, synchronous) clears the sequencer and all valid bits
module cubic_bezier_curve_flattener_top import cbf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
  // point_count, zero pad
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x, point_y
  output logic [31:0]  out_tdata,
  output logic         out_tlast
);

  localparam int DW  = $clog2(MAX_POINTS);      // step index / d width
  localparam int NW  = $clog2(MAX_POINTS + 1);  // point count width
  localparam int WW  = 3 * DW;                  // d^3 width
  localparam int WDW = WW + 2;                  // weights incl. factor 3
  localparam int PW  = COORD_W + WDW + 1;       // signed product width
  localparam int SW  = WW + 20;                 // signed sum width
  localparam int MW  = WW + 17;                 // biased numerator width

  typedef logic signed [COORD_W-1:0] coord_t;

  // global advance: move when the output register is free or being taken
  logic en;
  assign en = !out_tvalid || out_tready;

  // ---------------- sequencer ----------------
  logic            busy_r;
  logic [DW-1:0]   j_r;
  logic [DW-1:0]   d_r;
  coord_t          pts_r [NUM_COORDS];

  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    n_c;
  logic             in_xfer;

  // no transfer is taken while reset is held
  assign cnt       = in_tdata[134:128];
  assign in_tready = rst_n && !busy_r;
  assign in_xfer   = in_tvalid && in_tready;

  // clamp count into [MIN_POINTS, MAX_POINTS]
  always_comb begin
    if (cnt < CNT_W'(MIN_POINTS)) begin
      n_c = NW'(MIN_POINTS);
    end else if (32'(cnt) > 32'(MAX_POINTS)) begin
      n_c = NW'(MAX_POINTS);
    end else begin
      n_c = NW'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      j_r    <= '0;
      d_r    <= '0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
      j_r    <= '0;
      d_r    <= DW'(n_c - NW'(1));
    end else if (busy_r && en) begin
      j_r <= j_r + DW'(1);
      if (j_r == d_r) begin
        busy_r <= 1'b0;  // last step issued
      end
    end
  end

  // latch the control points of a new curve
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        pts_r[i] <= coord_t'(in_tdata[COORD_W*i +: COORD_W]);
      end
    end
  end

  // ---------------- stage 1: issued step ----------------
  logic          v1_r, last1_r;
  logic [DW-1:0] j1_r, u1_r, d1_r;
  coord_t        pts1_r [NUM_COORDS];

  // ---------------- stage 2: squares ----------------
  logic            v2_r, last2_r;
  logic [DW-1:0]   j2_r, u2_r, d2_r;
  logic [2*DW-1:0] uu2_r, jj2_r, dd2_r;
  coord_t          pts2_r [NUM_COORDS];

  // ---------------- stage 3: bernstein weights ----------------
  logic           v3_r, last3_r;
  logic [WDW-1:0] w0_r, w1_r, w2_r, w3_r;
  logic [WW-1:0]  den3_r;
  coord_t         pts3_r [NUM_COORDS];

  // ---------------- stage 4: products ----------------
  logic                 v4_r, last4_r;
  logic signed [PW-1:0] px_r [4];
  logic signed [PW-1:0] py_r [4];
  logic [WW-1:0]        den4_r;

  // ---------------- stage 5: partial sums ----------------
  logic                 v5_r, last5_r;
  logic signed [SW-1:0] sx01_r, sx23_r, sy01_r, sy23_r, bias5_r;
  logic [WW-1:0]        den5_r;

  // ---------------- stage 6: biased numerators ----------------
  logic          v6_r, last6_r;
  logic [MW-1:0] mx6_r, my6_r;
  logic [WW-1:0] den6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= busy_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      j1_r    <= j_r;
      u1_r    <= d_r - j_r;
      d1_r    <= d_r;
      last1_r <= (j_r == d_r);
      pts1_r  <= pts_r;
      // stage 2
      j2_r    <= j1_r;
      u2_r    <= u1_r;
      d2_r    <= d1_r;
      uu2_r   <= (2*DW)'(u1_r) * (2*DW)'(u1_r);
      jj2_r   <= (2*DW)'(j1_r) * (2*DW)'(j1_r);
      dd2_r   <= (2*DW)'(d1_r) * (2*DW)'(d1_r);
      last2_r <= last1_r;
      pts2_r  <= pts1_r;
      // stage 3: u^3, 3u^2j, 3uj^2, j^3 and d^3
      w0_r    <= WDW'(uu2_r) * WDW'(u2_r);
      w1_r    <= WDW'(uu2_r) * WDW'(j2_r) * WDW'(3);
      w2_r    <= WDW'(jj2_r) * WDW'(u2_r) * WDW'(3);
      w3_r    <= WDW'(jj2_r) * WDW'(j2_r);
      den3_r  <= WW'(dd2_r) * WW'(d2_r);
      last3_r <= last2_r;
      pts3_r  <= pts2_r;
      // stage 4: x from even entries, y from odd entries
      px_r[0] <= PW'(pts3_r[0]) * $signed(PW'(w0_r));
      px_r[1] <= PW'(pts3_r[2]) * $signed(PW'(w1_r));
      px_r[2] <= PW'(pts3_r[4]) * $signed(PW'(w2_r));
      px_r[3] <= PW'(pts3_r[6]) * $signed(PW'(w3_r));
      py_r[0] <= PW'(pts3_r[1]) * $signed(PW'(w0_r));
      py_r[1] <= PW'(pts3_r[3]) * $signed(PW'(w1_r));
      py_r[2] <= PW'(pts3_r[5]) * $signed(PW'(w2_r));
      py_r[3] <= PW'(pts3_r[7]) * $signed(PW'(w3_r));
      den4_r  <= den3_r;
      last4_r <= last3_r;
      // stage 5: rounding half plus offset 32768*den keeps the numerator non-negative
      sx01_r  <= SW'(px_r[0]) + SW'(px_r[1]);
      sx23_r  <= SW'(px_r[2]) + SW'(px_r[3]);
      sy01_r  <= SW'(py_r[0]) + SW'(py_r[1]);
      sy23_r  <= SW'(py_r[2]) + SW'(py_r[3]);
      bias5_r <= $signed(SW'(den4_r >> 1)) + $signed(SW'(den4_r) << (COORD_W - 1));
      den5_r  <= den4_r;
      last5_r <= last4_r;
      // stage 6
      mx6_r   <= MW'(sx01_r + sx23_r + bias5_r);
      my6_r   <= MW'(sy01_r + sy23_r + bias5_r);
      den6_r  <= den5_r;
      last6_r <= last5_r;
    end
  end

  // ---------------- divider, its last stage is the output register ----------------
  logic [COORD_W-1:0] qx, qy;

  cbf_div #(
    .DEN_W (WW),
    .NUM_W (MW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_last   (last6_r),
    .in_num_x  (mx6_r),
    .in_num_y  (my6_r),
    .in_den    (den6_r),
    .out_valid (out_tvalid),
    .out_last  (out_tlast),
    .out_q_x   (qx),
    .out_q_y   (qy)
  );

  // quotient carries the 32768 offset: flipping the sign bit removes it
  assign out_tdata = {qy ^ {1'b1, {(COORD_W-1){1'b0}}}, qx ^ {1'b1, {(COORD_W-1){1'b0}}}};

endmodule
